[src/clnp_pkg.sv]
// ----------------------------------------------------------------------------
// clnp_pkg: shared types and constants of the linked-cell pair search
// Command codes, register indexes, fixed field widths and the binning config.
// ----------------------------------------------------------------------------
package clnp_pkg;

  localparam int ID_W           = 10;
  localparam int LEN_W          = 16;
  localparam int DIM_W          = 7;
  localparam int CELL_OUT_W     = 12;
  localparam int CALC_W         = 18;
  localparam int NEIGHBOR_CELLS = 4;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_INV_X     = 3'd2;
  localparam logic [2:0] REG_INV_Y     = 3'd3;
  localparam logic [2:0] REG_CELLS_X   = 3'd4;
  localparam logic [2:0] REG_CELLS_Y   = 3'd5;
  localparam logic [2:0] REG_SKIN      = 3'd6;
  localparam logic [2:0] REG_SMALL_MAX = 3'd7;

  typedef struct packed {
    logic [LEN_W-1:0] origin_x;
    logic [LEN_W-1:0] origin_y;
    logic [LEN_W-1:0] inv_x;
    logic [LEN_W-1:0] inv_y;
    logic [DIM_W-1:0] gx;
    logic [DIM_W-1:0] gy;
  } bin_cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = 7'd1;
    else if (v > 7'd64) r = 7'd64;
    return r;
  endfunction

endpackage

[src/clnp_chan_if.sv]
// ----------------------------------------------------------------------------
// clnp channel interfaces
// Command channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface clnp_in_if import clnp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ID_W-1:0]   particle_id;
  logic [LEN_W-1:0]  pos_x;
  logic [LEN_W-1:0]  pos_y;
  logic [LEN_W-1:0]  radius;
  logic [LEN_W-1:0]  cutoff_factor;

  modport source(output valid, cmd, particle_id, pos_x, pos_y, radius, cutoff_factor,
                 input ready);
  modport sink(input valid, cmd, particle_id, pos_x, pos_y, radius, cutoff_factor,
               output ready);
endinterface

interface clnp_out_if import clnp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ID_W-1:0]       first_id;
  logic [ID_W-1:0]       second_id;
  logic [CELL_OUT_W-1:0] cell_index;
  logic                  pair_valid;
  logic                  overflow;
  logic                  last;

  modport source(output valid, first_id, second_id, cell_index, pair_valid, overflow, last,
                 input ready);
  modport sink(input valid, first_id, second_id, cell_index, pair_valid, overflow, last,
               output ready);
endinterface

[src/clnp_bin.sv]
// ----------------------------------------------------------------------------
// clnp_bin: cell binning pipeline
// Three register stages from a position to its clamped linear cell index.
// ----------------------------------------------------------------------------
module clnp_bin import clnp_pkg::*; #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                          clk,
  input  bin_cfg_t                      cfg,
  input  logic [LEN_W-1:0]              pos_x,
  input  logic [LEN_W-1:0]              pos_y,
  output logic [$clog2(MAX_CELLS)-1:0]  cell_idx
);

  localparam int CW = $clog2(MAX_CELLS);

  logic signed [16:0] dx, dy;
  logic signed [33:0] px_r, py_r;
  logic signed [14:0] fx, fy, limx, limy;
  logic [5:0]         cx_nxt, cy_nxt, cx_r, cy_r;
  logic [12:0]        csum;
  logic [CW-1:0]      cell_r;

  assign dx = signed'({1'b0, pos_x}) - signed'({1'b0, cfg.origin_x});
  assign dy = signed'({1'b0, pos_y}) - signed'({1'b0, cfg.origin_y});

  assign fx   = signed'({px_r[33], px_r[33:20]}) + 15'sd1;
  assign fy   = signed'({py_r[33], py_r[33:20]});
  assign limx = signed'({8'd0, cfg.gx - 7'd1});
  assign limy = signed'({8'd0, cfg.gy - 7'd1});

  always_comb begin
    if (fx < 0) cx_nxt = '0;
    else if (fx > limx) cx_nxt = limx[5:0];
    else cx_nxt = fx[5:0];
    if (fy < 0) cy_nxt = '0;
    else if (fy > limy) cy_nxt = limy[5:0];
    else cy_nxt = fy[5:0];
  end

  assign csum = 13'(cy_r) * 13'(cfg.gx) + 13'(cx_r);

  always_ff @(posedge clk) begin
    px_r <= dx * signed'({1'b0, cfg.inv_x});
    py_r <= dy * signed'({1'b0, cfg.inv_y});
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    if (int'(csum) > MAX_CELLS - 1) cell_r <= CW'(MAX_CELLS - 1);
    else cell_r <= CW'(csum);
  end

  assign cell_idx = cell_r;

endmodule

[src/cell_list_neighbor_pairs.sv]
// ----------------------------------------------------------------------------
// cell_list_neighbor_pairs: 2D linked-cell neighbor pair search
// Cell heads and particle records live in two synchronous memories; a
// sequencer bins inserts and walks five cell lists for each query.
// ----------------------------------------------------------------------------
//  channel  | direction | beat
//  in_ch    | sink      | cmd, particle_id, pos_x, pos_y, radius, cutoff_factor
//  out_ch   | source    | first_id, second_id, cell_index, pair_valid, overflow, last
//  cfg (APB)| slave     | eight registers at byte address 4*i
//
// After reset the head memory is cleared; no command is taken meanwhile.
// A query reads each list entry it visits through the single particle memory
// read port.
// A stalled result channel holds the walk when a further pair is found while the
// previous beat still waits, and holds the final beat.
// ----------------------------------------------------------------------------
module cell_list_neighbor_pairs import clnp_pkg::*; #(
  parameter int MAX_PARTICLES = 1024,
  parameter int MAX_CELLS     = 4096,
  parameter int MAX_PAIRS     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  clnp_in_if.sink     in_ch,
  clnp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW  = $clog2(MAX_PARTICLES);
  localparam int LW  = PW + 1;
  localparam int CW  = $clog2(MAX_CELLS);
  localparam int SW  = PW + 1;
  localparam int NW  = $clog2(MAX_PAIRS + 1);
  localparam int PMW = LW + 4 * LEN_W + CW;
  localparam int O_CUT  = CW;
  localparam int O_RAD  = CW + LEN_W;
  localparam int O_Y    = CW + 2 * LEN_W;
  localparam int O_X    = CW + 3 * LEN_W;
  localparam int O_NEXT = CW + 4 * LEN_W;
  localparam logic [LW-1:0] EMPTY = {LW{1'b1}};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INS_BIN, S_INS_RD, S_INS_WR, S_Q_RD, S_Q_CHK, S_Q_REACH,
    S_WALK, S_W_DATA, S_W_CMP, S_NEXT_CELL, S_HEAD, S_FIN
  } state_t;

  // Configuration registers.
  logic [LEN_W-1:0] origin_x_r, origin_y_r, inv_x_r, inv_y_r, skin_r, small_max_r;
  logic [DIM_W-1:0] cells_x_r, cells_y_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      inv_x_r     <= 16'd4096;
      inv_y_r     <= 16'd4096;
      cells_x_r   <= 7'd64;
      cells_y_r   <= 7'd64;
      skin_r      <= 16'd128;
      small_max_r <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_ORIGIN_X:  origin_x_r  <= pwdata[15:0];
        REG_ORIGIN_Y:  origin_y_r  <= pwdata[15:0];
        REG_INV_X:     inv_x_r     <= pwdata[15:0];
        REG_INV_Y:     inv_y_r     <= pwdata[15:0];
        REG_CELLS_X:   cells_x_r   <= pwdata[6:0];
        REG_CELLS_Y:   cells_y_r   <= pwdata[6:0];
        REG_SKIN:      skin_r      <= pwdata[15:0];
        REG_SMALL_MAX: small_max_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORIGIN_X:  prdata = 32'(origin_x_r);
      REG_ORIGIN_Y:  prdata = 32'(origin_y_r);
      REG_INV_X:     prdata = 32'(inv_x_r);
      REG_INV_Y:     prdata = 32'(inv_y_r);
      REG_CELLS_X:   prdata = 32'(cells_x_r);
      REG_CELLS_Y:   prdata = 32'(cells_y_r);
      REG_SKIN:      prdata = 32'(skin_r);
      REG_SMALL_MAX: prdata = 32'(small_max_r);
      default:       prdata = '0;
    endcase
  end

  // Grid size.
  logic [DIM_W-1:0]         gx, gy;
  logic [12:0]              gxgy;
  logic signed [CALC_W-1:0] total_s, gxs;
  bin_cfg_t                 bin_cfg;

  assign gx   = clamp_dim(cells_x_r);
  assign gy   = clamp_dim(cells_y_r);
  assign gxgy = 13'(gx) * 13'(gy);
  assign gxs  = signed'(CALC_W'(gx));
  assign total_s = (int'(gxgy) > MAX_CELLS) ? signed'(CALC_W'(MAX_CELLS))
                                            : signed'(CALC_W'(gxgy));
  assign bin_cfg = '{origin_x: origin_x_r, origin_y: origin_y_r, inv_x: inv_x_r,
                     inv_y: inv_y_r, gx: gx, gy: gy};

  // Sequencer state.
  state_t            state_r;
  logic [CW-1:0]     clr_cnt_r;
  logic              clr_reply_r;
  logic [ID_W-1:0]   id_r;
  logic [LEN_W-1:0]  pos_x_r, pos_y_r, rad_r, cut_r;
  logic [1:0]        wait_r;
  logic [LEN_W-1:0]  x1_r, y1_r;
  logic [CW-1:0]     cell_q_r;
  logic [31:0]       prod_r;
  logic [20:0]       reach_r;
  logic [LW-1:0]     cur_r, cand_r;
  logic [SW-1:0]     steps_r;
  logic [2:0]        sten_r;
  logic [32:0]       dx2_r, dy2_r;
  logic [43:0]       lim2_r;
  logic              small_r;
  logic [NW-1:0]     cnt_r;
  logic              over_r;
  logic [ID_W-1:0]   pend_first_r, pend_second_r;
  logic [CELL_OUT_W-1:0] pend_cell_r;
  logic              pend_pv_r;
  logic              out_valid_r, out_pv_r, out_over_r, out_last_r;
  logic [ID_W-1:0]   out_first_r, out_second_r;
  logic [CELL_OUT_W-1:0] out_cell_r;

  // Memories.
  logic [LW-1:0]  head_mem [MAX_CELLS];
  logic [PMW-1:0] pmem [MAX_PARTICLES];
  logic [LW-1:0]  head_q_r;
  logic [PMW-1:0] pm_q_r;
  logic           head_we, pm_we;
  logic [CW-1:0]  head_wa, head_ra;
  logic [LW-1:0]  head_wd;
  logic [PW-1:0]  pm_ra;

  logic [CW-1:0]            bin_cell;
  logic                     id_ok, cur_ok, steps_done, slot_free, hit, c2_ok;
  logic                     out_load;
  logic signed [CALC_W-1:0] c2, off;
  logic signed [16:0]       dx, dy;
  logic [21:0]              lim;
  logic [33:0]              dsum;

  clnp_bin #(.MAX_CELLS(MAX_CELLS)) u_bin (
    .clk      (clk),
    .cfg      (bin_cfg),
    .pos_x    (pos_x_r),
    .pos_y    (pos_y_r),
    .cell_idx (bin_cell)
  );

  assign id_ok      = int'(id_r) < MAX_PARTICLES;
  assign cur_ok     = int'(cur_r) < MAX_PARTICLES;
  assign steps_done = steps_r == SW'(MAX_PARTICLES);
  assign slot_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    case (sten_r)
      3'd0:    off = -gxs - 18'sd1;
      3'd1:    off = -18'sd1;
      3'd2:    off = gxs - 18'sd1;
      default: off = -gxs;
    endcase
  end
  assign c2    = signed'(CALC_W'(cell_q_r)) + off;
  assign c2_ok = (c2 >= 0) && (c2 < total_s);

  assign dx   = signed'({1'b0, x1_r}) - signed'({1'b0, pm_q_r[O_X +: LEN_W]});
  assign dy   = signed'({1'b0, y1_r}) - signed'({1'b0, pm_q_r[O_Y +: LEN_W]});
  assign lim  = 22'(reach_r) + 22'(pm_q_r[O_RAD +: LEN_W]);
  assign dsum = 34'(dx2_r) + 34'(dy2_r);
  assign hit  = small_r && (44'(dsum) < lim2_r);

  assign out_load = slot_free &&
                    ((state_r == S_FIN) ||
                     (state_r == S_W_CMP && hit && int'(cnt_r) < MAX_PAIRS &&
                      cnt_r != '0));

  always_comb begin
    head_we = 1'b0;
    head_wa = bin_cell;
    head_wd = LW'(id_r);
    head_ra = bin_cell;
    pm_we   = 1'b0;
    pm_ra   = PW'(cur_r);
    case (state_r)
      S_CLR: begin
        head_we = 1'b1;
        head_wa = clr_cnt_r;
        head_wd = EMPTY;
      end
      S_INS_WR: begin
        head_we = id_ok;
        pm_we   = id_ok;
      end
      S_NEXT_CELL: head_ra = CW'(c2);
      S_Q_RD:      pm_ra   = PW'(id_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (pm_we) pmem[PW'(id_r)] <= {head_q_r, pos_x_r, pos_y_r, rad_r, cut_r, bin_cell};
    pm_q_r <= pmem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CW'(MAX_CELLS - 1)) state_r <= clr_reply_r ? S_FIN : S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            id_r    <= in_ch.particle_id;
            pos_x_r <= in_ch.pos_x;
            pos_y_r <= in_ch.pos_y;
            rad_r   <= in_ch.radius;
            cut_r   <= in_ch.cutoff_factor;
            pend_first_r  <= (in_ch.cmd == CMD_INSERT || in_ch.cmd == CMD_QUERY)
                             ? in_ch.particle_id : '0;
            pend_second_r <= '0;
            pend_cell_r   <= '0;
            pend_pv_r     <= 1'b0;
            cnt_r   <= '0;
            over_r  <= 1'b0;
            wait_r  <= '0;
            case (in_ch.cmd)
              CMD_CLEAR: begin
                state_r     <= S_CLR;
                clr_cnt_r   <= '0;
                clr_reply_r <= 1'b1;
              end
              CMD_INSERT: state_r <= S_INS_BIN;
              CMD_QUERY:  state_r <= S_Q_RD;
              default:    state_r <= S_FIN;
            endcase
          end
        end
        S_INS_BIN: begin
          wait_r <= wait_r + 1'b1;
          if (wait_r == 2'd2) state_r <= S_INS_RD;
        end
        S_INS_RD: begin
          pend_cell_r <= CELL_OUT_W'(bin_cell);
          state_r     <= S_INS_WR;
        end
        S_INS_WR: state_r <= S_FIN;
        S_Q_RD:   state_r <= id_ok ? S_Q_CHK : S_FIN;
        S_Q_CHK: begin
          x1_r     <= pm_q_r[O_X +: LEN_W];
          y1_r     <= pm_q_r[O_Y +: LEN_W];
          cell_q_r <= pm_q_r[CW-1:0];
          cur_r    <= pm_q_r[O_NEXT +: LW];
          prod_r   <= 32'(pm_q_r[O_RAD +: LEN_W]) * 32'(pm_q_r[O_CUT +: LEN_W]);
          steps_r  <= '0;
          sten_r   <= '0;
          state_r  <= (pm_q_r[O_RAD +: LEN_W] > small_max_r) ? S_FIN : S_Q_REACH;
        end
        S_Q_REACH: begin
          reach_r <= 21'(prod_r[31:12]) + 21'(skin_r);
          state_r <= S_WALK;
        end
        S_WALK: begin
          cand_r  <= cur_r;
          state_r <= (steps_done || !cur_ok) ? S_NEXT_CELL : S_W_DATA;
        end
        S_W_DATA: begin
          dx2_r   <= 33'(34'(dx) * 34'(dx));
          dy2_r   <= 33'(34'(dy) * 34'(dy));
          lim2_r  <= lim * lim;
          small_r <= pm_q_r[O_RAD +: LEN_W] < small_max_r;
          cur_r   <= pm_q_r[O_NEXT +: LW];
          steps_r <= steps_r + 1'b1;
          state_r <= S_W_CMP;
        end
        S_W_CMP: begin
          if (!hit) begin
            state_r <= S_WALK;
          end else if (int'(cnt_r) >= MAX_PAIRS) begin
            over_r  <= 1'b1;
            state_r <= S_WALK;
          end else if (cnt_r == '0 || slot_free) begin
            if (cnt_r != '0) begin
              out_first_r  <= pend_first_r;
              out_second_r <= pend_second_r;
              out_cell_r   <= pend_cell_r;
              out_pv_r     <= pend_pv_r;
              out_over_r   <= 1'b0;
              out_last_r   <= 1'b0;
            end
            pend_second_r <= ID_W'(cand_r);
            pend_pv_r     <= 1'b1;
            cnt_r         <= cnt_r + 1'b1;
            state_r       <= S_WALK;
          end
        end
        S_NEXT_CELL: begin
          if (sten_r == 3'(NEIGHBOR_CELLS)) begin
            state_r <= S_FIN;
          end else begin
            sten_r <= sten_r + 1'b1;
            if (c2_ok) state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur_r   <= head_q_r;
          steps_r <= '0;
          state_r <= S_WALK;
        end
        S_FIN: begin
          if (slot_free) begin
            out_first_r  <= pend_first_r;
            out_second_r <= pend_second_r;
            out_cell_r   <= pend_cell_r;
            out_pv_r     <= pend_pv_r;
            out_over_r   <= over_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = state_r == S_IDLE;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.first_id   = out_first_r;
  assign out_ch.second_id  = out_second_r;
  assign out_ch.cell_index = out_cell_r;
  assign out_ch.pair_valid = out_pv_r;
  assign out_ch.overflow   = out_over_r;
  assign out_ch.last       = out_last_r;

endmodule

[src/clnp_checker.sv]
// ----------------------------------------------------------------------------
// clnp_checker: port-level checks of the pair search
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module clnp_checker import clnp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ID_W-1:0]       out_first_id,
  input logic [ID_W-1:0]       out_second_id,
  input logic                  out_pair_valid,
  input logic                  out_overflow,
  input logic                  out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_nopair_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |-> out_last && out_second_id == '0)
    else $error("beat without a pair is not the final one");

  a_over_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last && out_pair_valid)
    else $error("overflow away from a final pair beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_id) && $stable(out_last))
    else $error("stalled result beat changed");

endmodule

bind cell_list_neighbor_pairs clnp_checker u_clnp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_first_id   (out_ch.first_id),
  .out_second_id  (out_ch.second_id),
  .out_pair_valid (out_ch.pair_valid),
  .out_overflow   (out_ch.overflow),
  .out_last       (out_ch.last)
);

[sim/cell_list_neighbor_pairs_test.sv]
// ----------------------------------------------------------------------------
// cell_list_neighbor_pairs_test: self-checking bench of the linked-cell search
// A directed table and random command streams drive the command channel under
// three idle patterns and several register settings; a local model of the cell
// lists predicts every result beat, which is checked in order, field by field.
// ----------------------------------------------------------------------------
module cell_list_neighbor_pairs_test;
  import clnp_pkg::*;

  localparam logic [1:0] CMD_NOP  = 2'd3;
  localparam int NPART    = 1024;
  localparam int NCELL    = 4096;
  localparam int PAIR_CAP = 64;
  localparam int WD_LIMIT = 100000;

  typedef struct packed {
    logic [ID_W-1:0]       first_id;
    logic [ID_W-1:0]       second_id;
    logic [CELL_OUT_W-1:0] cell_index;
    logic                  pair_valid;
    logic                  overflow;
    logic                  last;
  } beat_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] px;
    logic [LEN_W-1:0] py;
    logic [LEN_W-1:0] rad;
    logic [LEN_W-1:0] cf;
    logic             typed;
    logic [CELL_OUT_W-1:0] tcell;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  clnp_in_if in_ch();
  clnp_out_if out_ch();

  cell_list_neighbor_pairs u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the block's registers and memories.
  longint m_org_x, m_org_y, m_inv_x, m_inv_y, m_cells_x, m_cells_y, m_skin, m_small;
  int     head_of[NCELL];
  int     link_of[NPART];
  longint px_of[NPART], py_of[NPART], rad_of[NPART], cf_of[NPART], cell_of[NPART];
  bit     ever_in[NPART];
  bit     live_in[NPART];
  int     inserted_ids[$];

  beat_t  pending_beats[$];
  beat_t  step_beats[$];
  bit     step_over;
  int     mismatches = 0;
  int     idle_in = 0, idle_out = 0;
  int     quiet_cycles = 0;
  bit     in_fire, out_fire;

  function automatic longint grid_dim(longint v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic longint bin_floor(longint pos, longint org, longint inv);
    longint p;
    p = (pos - org) * inv;
    if (p >= 0) return p >>> 20;
    return -((-p + 64'hFFFFF) >>> 20);
  endfunction

  function automatic longint clip(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void push_beat(longint a, longint b, longint c, bit pv);
    beat_t e;
    e = '0;
    e.first_id = a[ID_W-1:0];
    e.second_id = b[ID_W-1:0];
    e.cell_index = c[CELL_OUT_W-1:0];
    e.pair_valid = pv;
    step_beats.push_back(e);
  endfunction

  function automatic void walk_cell_list(int id1, int id2, longint reach);
    longint dx, dy, rsq, lim;
    for (int s = 0; s < NPART; s++) begin
      if (id2 < 0 || id2 >= NPART) return;
      if (rad_of[id2] < m_small) begin
        dx = px_of[id1] - px_of[id2];
        dy = py_of[id1] - py_of[id2];
        rsq = dx * dx + dy * dy;
        lim = reach + rad_of[id2];
        if (rsq < lim * lim) begin
          if (step_beats.size() < PAIR_CAP) push_beat(id1, id2, 0, 1'b1);
          else step_over = 1'b1;
        end
      end
      id2 = link_of[id2];
    end
  endfunction

  function automatic void predict_pairs(row_t it);
    longint gx, gy, total, cx, cy, c, c2, reach;
    longint offs[4];
    int id;
    gx = grid_dim(m_cells_x);
    gy = grid_dim(m_cells_y);
    total = gx * gy;
    id = int'(it.id);
    step_beats.delete();
    step_over = 1'b0;
    if (total > NCELL) total = NCELL;
    case (it.cmd)
      CMD_CLEAR: begin
        foreach (head_of[i]) head_of[i] = -1;
        foreach (live_in[i]) live_in[i] = 1'b0;
        push_beat(0, 0, 0, 1'b0);
      end
      CMD_INSERT: begin
        cx = clip(bin_floor(longint'(it.px), m_org_x, m_inv_x) + 1, gx - 1);
        cy = clip(bin_floor(longint'(it.py), m_org_y, m_inv_y), gy - 1);
        c = clip(cy * gx + cx, NCELL - 1);
        link_of[id] = head_of[c];
        head_of[c] = id;
        px_of[id] = longint'(it.px);
        py_of[id] = longint'(it.py);
        rad_of[id] = longint'(it.rad);
        cf_of[id] = longint'(it.cf);
        cell_of[id] = c;
        if (!ever_in[id]) inserted_ids.push_back(id);
        ever_in[id] = 1'b1;
        live_in[id] = 1'b1;
        push_beat(id, 0, c, 1'b0);
      end
      CMD_QUERY: begin
        if (rad_of[id] <= m_small) begin
          c = cell_of[id];
          reach = ((rad_of[id] * cf_of[id]) >> 12) + m_skin;
          offs[0] = -gx - 1;
          offs[1] = -1;
          offs[2] = gx - 1;
          offs[3] = -gx;
          walk_cell_list(id, link_of[id], reach);
          for (int s = 0; s < 4; s++) begin
            c2 = c + offs[s];
            if (c2 >= 0 && c2 < total) walk_cell_list(id, head_of[c2], reach);
          end
        end
        if (step_beats.size() == 0) push_beat(id, 0, 0, 1'b0);
      end
      default: push_beat(0, 0, 0, 1'b0);
    endcase
    step_beats[step_beats.size() - 1].overflow = step_over;
    step_beats[step_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_command(row_t it);
    bit acc;
    while ($urandom_range(99) < idle_in) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.particle_id <= it.id;
    in_ch.pos_x <= it.px;
    in_ch.pos_y <= it.py;
    in_ch.radius <= it.rad;
    in_ch.cutoff_factor <= it.cf;
    do begin
      @(negedge clk);
      acc = in_ch.ready;
      @(posedge clk);
    end while (!acc);
    predict_pairs(it);
    if (it.typed) begin
      step_beats[0].first_id = (it.cmd == CMD_INSERT || it.cmd == CMD_QUERY) ? it.id : '0;
      step_beats[0].second_id = '0;
      step_beats[0].cell_index = it.tcell;
      step_beats[0].pair_valid = 1'b0;
      step_beats[0].overflow = 1'b0;
      step_beats[0].last = 1'b1;
    end
    foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ORIGIN_X:  m_org_x = longint'(val[15:0]);
      REG_ORIGIN_Y:  m_org_y = longint'(val[15:0]);
      REG_INV_X:     m_inv_x = longint'(val[15:0]);
      REG_INV_Y:     m_inv_y = longint'(val[15:0]);
      REG_CELLS_X:   m_cells_x = longint'(val[6:0]);
      REG_CELLS_Y:   m_cells_y = longint'(val[6:0]);
      REG_SKIN:      m_skin = longint'(val[15:0]);
      default:       m_small = longint'(val[15:0]);
    endcase
  endtask

  task automatic load_setting(logic [15:0] ox, logic [15:0] oy, logic [15:0] ix,
                              logic [15:0] iy, logic [6:0] gx, logic [6:0] gy,
                              logic [15:0] sk, logic [15:0] sm);
    drain_results();
    wait_cycles(NCELL + 100);
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_INV_X, 32'(ix));
    write_reg(REG_INV_Y, 32'(iy));
    write_reg(REG_CELLS_X, 32'(gx));
    write_reg(REG_CELLS_Y, 32'(gy));
    write_reg(REG_SKIN, 32'(sk));
    write_reg(REG_SMALL_MAX, 32'(sm));
  endtask

  function automatic int fresh_id();
    int id;
    for (int t = 0; t < 50; t++) begin
      id = $urandom_range(NPART - 1);
      if (!live_in[id]) return id;
    end
    return id;
  endfunction

  function automatic row_t random_command(longint base);
    row_t it;
    int pick;
    it = '0;
    pick = $urandom_range(99);
    if (pick < 6) it.cmd = CMD_CLEAR;
    else if (pick < 8) it.cmd = CMD_NOP;
    else if (pick < 55 || inserted_ids.size() == 0) it.cmd = CMD_INSERT;
    else it.cmd = CMD_QUERY;
    it.id = ID_W'($urandom_range(NPART - 1));
    it.px = LEN_W'($urandom_range(65535));
    it.py = LEN_W'($urandom_range(65535));
    it.rad = LEN_W'($urandom_range(65535));
    it.cf = LEN_W'($urandom_range(65535));
    if (it.cmd == CMD_INSERT) begin
      it.id = ($urandom_range(99) < 5) ? ID_W'($urandom_range(NPART - 1))
                                       : ID_W'(fresh_id());
      if ($urandom_range(99) < 80) begin
        it.px = LEN_W'(base + $urandom_range(16'h0600));
        it.py = LEN_W'(base + $urandom_range(16'h0600));
      end
      if ($urandom_range(99) < 85) it.rad = LEN_W'($urandom_range(16'h01FF));
      if ($urandom_range(99) < 85) it.cf = LEN_W'($urandom_range(16'h0800, 16'h2000));
    end else if (it.cmd == CMD_QUERY) begin
      it.id = ID_W'(inserted_ids[$urandom_range(inserted_ids.size() - 1)]);
    end
    return it;
  endfunction

  task automatic random_phase(int n, longint base);
    int hold_at;
    hold_at = $urandom_range(n - 1);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) drain_results();
      send_command(random_command(base));
    end
  endtask

  task automatic packed_cell_burst();
    row_t it;
    it = '0;
    it.cmd = CMD_CLEAR;
    send_command(it);
    for (int k = 0; k < 68; k++) begin
      it.cmd = CMD_INSERT;
      it.id = ID_W'(100 + k);
      it.px = LEN_W'(16'h0400 + (k % 8));
      it.py = 16'h0400;
      it.rad = 16'h0040;
      it.cf = 16'h1000;
      send_command(it);
    end
    it.cmd = CMD_QUERY;
    it.id = 10'd167;
    send_command(it);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= idle_out);
  end

  always @(negedge clk) begin
    beat_t got, want;
    in_fire = in_ch.valid && in_ch.ready;
    out_fire = out_ch.valid && out_ch.ready;
    if (rst_n && out_fire) begin
      got.first_id = out_ch.first_id;
      got.second_id = out_ch.second_id;
      got.cell_index = out_ch.cell_index;
      got.pair_valid = out_ch.pair_valid;
      got.overflow = out_ch.overflow;
      got.last = out_ch.last;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  row_t directed[16];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.particle_id = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.radius = '0;
    in_ch.cutoff_factor = '0;
    m_org_x = 0; m_org_y = 0; m_inv_x = 4096; m_inv_y = 4096;
    m_cells_x = 64; m_cells_y = 64; m_skin = 128; m_small = 256;
    foreach (head_of[i]) head_of[i] = -1;
    foreach (link_of[i]) begin
      link_of[i] = 0; px_of[i] = 0; py_of[i] = 0;
      rad_of[i] = 0; cf_of[i] = 0; cell_of[i] = 0;
    end
    //            cmd         id    px        py        rad       cf      typed cell
    directed[0]  = {CMD_CLEAR,  10'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 12'd0};
    directed[1]  = {CMD_NOP,    10'd5,    16'h1234, 16'h4321, 16'h0010, 16'h1000, 1'b1, 12'd0};
    directed[2]  = {CMD_INSERT, 10'd0,    16'h0000, 16'h0000, 16'h0080, 16'h1000, 1'b1, 12'd1};
    directed[3]  = {CMD_INSERT, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'd4095};
    directed[4]  = {CMD_INSERT, 10'd2,    16'h0100, 16'h0000, 16'h0080, 16'h1000, 1'b1, 12'd2};
    directed[5]  = {CMD_INSERT, 10'd3,    16'h0180, 16'h0100, 16'h00FF, 16'h1000, 1'b1, 12'd66};
    directed[6]  = {CMD_INSERT, 10'd4,    16'h0100, 16'h0100, 16'h0100, 16'h1000, 1'b1, 12'd66};
    directed[7]  = {CMD_QUERY,  10'd1023, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 12'd0};
    directed[8]  = {CMD_QUERY,  10'd2,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 12'd0};
    directed[9]  = {CMD_QUERY,  10'd3,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 12'd0};
    directed[10] = {CMD_QUERY,  10'd4,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 12'd0};
    directed[11] = {CMD_QUERY,  10'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 12'd0};
    directed[12] = {CMD_INSERT, 10'd5,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 12'd1};
    directed[13] = {CMD_QUERY,  10'd5,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 12'd0};
    directed[14] = {CMD_CLEAR,  10'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 12'd0};
    directed[15] = {CMD_QUERY,  10'd2,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 12'd0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    idle_in = 37;
    idle_out = 53;
    foreach (directed[i]) send_command(directed[i]);
    packed_cell_burst();
    random_phase(22, 0);

    idle_in = 53;
    idle_out = 37;
    load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd1, 7'd0, 16'hFFFF, 16'hFFFF);
    random_phase(22, 0);

    idle_in = 0;
    idle_out = 0;
    load_setting(16'h0100, 16'h0000, 16'h8000, 16'h0000, 7'd127, 7'd3, 16'h0000, 16'h0200);
    random_phase(22, 256);

    drain_results();
    wait_cycles(NCELL + 100);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/clnp_pkg.sv
src/clnp_chan_if.sv
src/clnp_bin.sv
src/cell_list_neighbor_pairs.sv
src/clnp_checker.sv
sim/cell_list_neighbor_pairs_test.sv
